@@ rtl/core/gme_pkg.sv @@
// Shared types and constants of the graph minimum erosion unit.
`default_nettype none

package gme_pkg;

  // Item kinds carried on the input channel's tuser.
  localparam logic [1:0] KIND_WRITE_VALUE = 2'd0;
  localparam logic [1:0] KIND_WRITE_SLOT  = 2'd1;
  localparam logic [1:0] KIND_RUN         = 2'd2;
  localparam logic [1:0] KIND_READ        = 2'd3;

  // Register indexes, taken from address bit 2.
  localparam logic REG_PASS_COUNT = 1'b0;
  localparam logic REG_NODE_COUNT = 1'b1;

  localparam int PASS_COUNT_BITS = 8;
  localparam int NODE_COUNT_BITS = 11;
  localparam int CFG_ADDR_BITS   = 3;
  localparam int CFG_DATA_BITS   = 32;

  localparam logic [PASS_COUNT_BITS-1:0] PASS_COUNT_RESET = 8'd2;
  localparam logic [NODE_COUNT_BITS-1:0] NODE_COUNT_RESET = 11'd1024;

  // Input field widths.
  localparam int KIND_BITS   = 2;
  localparam int NODE_BITS   = 10;
  localparam int SLOT_BITS   = 3;
  localparam int IN_VAL_BITS = 32;
  localparam int OUT_BITS    = 32;

  // One adjacency entry: valid bit above the neighbor index.
  localparam int ADJ_BITS = NODE_BITS + 1;

  typedef struct packed {
    logic [PASS_COUNT_BITS-1:0] pass_count;
    logic [NODE_COUNT_BITS-1:0] node_count;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/gme_regs.sv @@
// Configuration register file of the graph minimum erosion unit.
`default_nettype none

module gme_regs (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [gme_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  wire  [gme_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [gme_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output gme_pkg::cfg_t                       cfg
);

  gme_pkg::cfg_t cfg_r;
  gme_pkg::cfg_t cfg_nxt;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[2])
        gme_pkg::REG_PASS_COUNT: cfg_nxt.pass_count = pwdata[gme_pkg::PASS_COUNT_BITS-1:0];
        gme_pkg::REG_NODE_COUNT: cfg_nxt.node_count = pwdata[gme_pkg::NODE_COUNT_BITS-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gme_pkg::REG_PASS_COUNT: prdata = gme_pkg::CFG_DATA_BITS'(cfg_r.pass_count);
      gme_pkg::REG_NODE_COUNT: prdata = gme_pkg::CFG_DATA_BITS'(cfg_r.node_count);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pass_count <= gme_pkg::PASS_COUNT_RESET;
      cfg_r.node_count <= gme_pkg::NODE_COUNT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/graph_min_erosion_unit.sv @@
// Top level of the graph minimum erosion unit: item decode, memories and pass sequencer.
`default_nettype none

// Morphological erosion on a graph held in three memories, each with one write port and
// one read port: node values, a pass buffer with the previous pass, and an adjacency
// table of MAX_DEGREE slots per node. After reset the unit sweeps the adjacency table
// once to mark every slot empty; no input beat is taken meanwhile, but configuration
// writes are. A read's answer enters the output register at the edge after the one that
// accepts its beat, from the node value memory port, and the next item is taken once
// the answer sits in the output register. A run item gives one completion beat after
// pass_count passes; each pass first copies the n nodes in use into the pass buffer and
// then streams MAX_DEGREE+1 reads per node through the single read port of the pass
// buffer into the read pipeline (adjacency read, stage 1, stage 2). Neighbor indexes at
// or beyond the node count are skipped, and node_count saturates at MAX_NODES.
module graph_min_erosion_unit #(
  parameter int MAX_NODES  = 1024,
  parameter int MAX_DEGREE = 8,
  parameter int VALUE_BITS = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // Input channel.
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // node_index[9:0], slot[12:10], neighbor_index[22:13], neighbor_valid[23],
  // value[55:24]
  input  wire  [55:0]                        in_tdata,
  // kind[1:0]
  input  wire  [1:0]                         in_tuser,
  // Result channel.
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // read_value[31:0]
  output logic [31:0]                        out_tdata,
  // is_done[0]
  output logic [0:0]                         out_tuser,
  // Configuration port.
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire  [gme_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  wire  [gme_pkg::CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic [gme_pkg::CFG_DATA_BITS-1:0]  cfg_prdata,
  output logic                               cfg_pready
);

  localparam int IW     = $clog2(MAX_NODES);
  localparam int NCW    = $clog2(MAX_NODES + 1);
  localparam int ADEPTH = MAX_NODES * MAX_DEGREE;
  localparam int AW     = $clog2(ADEPTH);
  localparam int OPW    = $clog2(MAX_DEGREE + 1);
  localparam int NB     = gme_pkg::NODE_BITS;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_COPY  = 6'b000100,
    ST_CALC  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  // Configuration registers.
  gme_pkg::cfg_t cfg;

  gme_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Input beat fields.
  logic [1:0]                            in_kind;
  logic [NB-1:0]                         in_node;
  logic [gme_pkg::SLOT_BITS-1:0]         in_slot;
  logic [NB-1:0]                         in_nbr;
  logic                                  in_nvalid;
  logic signed [gme_pkg::IN_VAL_BITS-1:0] in_value;

  assign in_node   = in_tdata[9:0];
  assign in_slot   = in_tdata[12:10];
  assign in_nbr    = in_tdata[22:13];
  assign in_nvalid = in_tdata[23];
  assign in_value  = in_tdata[55:24];
  assign in_kind   = in_tuser;

  // Control state.
  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [NCW-1:0]    n_r, n_nxt;
  logic [gme_pkg::PASS_COUNT_BITS-1:0] pass_left_r, pass_left_nxt;
  logic [IW-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]     node_r, node_nxt;
  logic [OPW-1:0]    op_r, op_nxt;
  logic [AW-1:0]     adj_addr_r, adj_addr_nxt;
  logic [NCW-1:0]    n_eff;
  logic [IW-1:0]     last_node;

  // Copy pipeline: node value read, then pass buffer write.
  logic              cp_vld_r;
  logic [IW-1:0]     cp_addr_r;

  // Erosion pipeline: stage 1 has adjacency data, stage 2 has pass buffer data.
  logic              s1_vld_r, s1_self_r, s1_last_r;
  logic [IW-1:0]     s1_node_r;
  logic              s2_vld_r, s2_self_r, s2_last_r, s2_use_r;
  logic [IW-1:0]     s2_node_r;
  logic [VALUE_BITS-1:0] best_r, best_new;

  // Read answer and output register.
  logic              rd_pend_r, rd_ok_r;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;
  logic              out_done_r, out_done_nxt;
  logic              out_free;

  logic              in_accept;
  logic              in_range;
  logic              slot_range;

  // Memories.
  logic [VALUE_BITS-1:0]      nv_mem [MAX_NODES];
  logic [VALUE_BITS-1:0]      pb_mem [MAX_NODES];
  logic [gme_pkg::ADJ_BITS-1:0] adj_mem [ADEPTH];

  logic                       nv_we, nv_re;
  logic [IW-1:0]              nv_waddr, nv_raddr;
  logic [VALUE_BITS-1:0]      nv_wdata, nv_rdata_r;
  logic                       pb_re;
  logic [IW-1:0]              pb_raddr;
  logic [VALUE_BITS-1:0]      pb_rdata_r;
  logic                       adj_we, adj_re;
  logic [AW-1:0]              adj_waddr;
  logic [gme_pkg::ADJ_BITS-1:0] adj_wdata, adj_rdata_r;
  logic [NB-1:0]              adj_idx;
  logic                       adj_valid;
  logic                       s1_use;

  assign n_eff = (32'(cfg.node_count) > 32'(MAX_NODES)) ? NCW'(MAX_NODES)
                                                         : NCW'(cfg.node_count);
  assign last_node  = IW'(n_r - NCW'(1));
  assign in_range   = 32'(in_node) < 32'(MAX_NODES);
  assign slot_range = 32'(in_slot) < 32'(MAX_DEGREE);

  // The output register is free this cycle or frees at this edge.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && !rd_pend_r &&
                     (out_free || in_kind == gme_pkg::KIND_WRITE_VALUE ||
                      in_kind == gme_pkg::KIND_WRITE_SLOT);
  assign in_accept = in_tvalid && in_tready;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    n_nxt         = n_r;
    pass_left_nxt = pass_left_r;
    cnt_nxt       = cnt_r;
    node_nxt      = node_r;
    op_nxt        = op_r;
    adj_addr_nxt  = adj_addr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(ADEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept && in_kind == gme_pkg::KIND_RUN) begin
          n_nxt         = n_eff;
          pass_left_nxt = cfg.pass_count;
          cnt_nxt       = '0;
          if (cfg.pass_count == '0 || n_eff == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        cnt_nxt = cnt_r + IW'(1);
        if (cnt_r == last_node) begin
          state_nxt    = ST_CALC;
          node_nxt     = '0;
          op_nxt       = '0;
          adj_addr_nxt = '0;
        end
      end
      ST_CALC: begin
        if (op_r != '0) begin
          adj_addr_nxt = adj_addr_r + AW'(1);
        end
        if (op_r == OPW'(MAX_DEGREE)) begin
          op_nxt   = '0;
          node_nxt = node_r + IW'(1);
          if (node_r == last_node) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          op_nxt = op_r + OPW'(1);
        end
      end
      ST_DRAIN: begin
        // Wait until the last node's write-back has landed.
        if (!s1_vld_r && !s2_vld_r) begin
          pass_left_nxt = pass_left_r - 8'd1;
          cnt_nxt       = '0;
          if (pass_left_r == 8'd1) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_COPY;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Node value memory: written by value writes and by write-back, read by reads and copy.
  assign nv_re    = (state_r == ST_COPY) || (in_accept && in_kind == gme_pkg::KIND_READ);
  assign nv_raddr = (state_r == ST_COPY) ? cnt_r : IW'(in_node);
  assign nv_we    = (s2_vld_r && s2_last_r) ||
                    (in_accept && in_kind == gme_pkg::KIND_WRITE_VALUE && in_range);
  assign nv_waddr = s2_vld_r ? s2_node_r : IW'(in_node);
  assign nv_wdata = s2_vld_r ? best_new : VALUE_BITS'(in_value);

  always_ff @(posedge clk) begin
    if (nv_we) begin
      nv_mem[nv_waddr] <= nv_wdata;
    end
    if (nv_re) begin
      nv_rdata_r <= nv_mem[nv_raddr];
    end
  end

  // Pass buffer: filled by the copy sweep, read by the erosion pipeline.
  always_ff @(posedge clk) begin
    if (cp_vld_r) begin
      pb_mem[cp_addr_r] <= nv_rdata_r;
    end
    if (pb_re) begin
      pb_rdata_r <= pb_mem[pb_raddr];
    end
  end

  // Adjacency table: cleared after reset, written by slot writes, read during passes.
  assign adj_we    = (state_r == ST_CLEAR) ||
                     (in_accept && in_kind == gme_pkg::KIND_WRITE_SLOT && in_range &&
                      slot_range);
  assign adj_waddr = (state_r == ST_CLEAR) ? clr_addr_r
                                           : AW'(AW'(in_node) * AW'(MAX_DEGREE) + AW'(in_slot));
  assign adj_wdata = (state_r == ST_CLEAR) ? '0 : {in_nvalid, in_nbr};
  assign adj_re    = (state_r == ST_CALC) && (op_r != '0);

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rdata_r <= adj_mem[adj_addr_r];
    end
  end

  // Stage 1: pick the pass buffer address, self or a neighbor in use.
  assign adj_idx   = adj_rdata_r[NB-1:0];
  assign adj_valid = adj_rdata_r[NB];
  assign s1_use    = s1_self_r || (adj_valid && 32'(adj_idx) < 32'(n_r));
  assign pb_re     = s1_vld_r;
  assign pb_raddr  = s1_self_r ? s1_node_r : IW'(adj_idx);

  // Stage 2: running minimum; the node's own value seeds it.
  always_comb begin
    best_new = best_r;
    if (s2_self_r) begin
      best_new = pb_rdata_r;
    end else if (s2_use_r && ($signed(pb_rdata_r) < $signed(best_r))) begin
      best_new = pb_rdata_r;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_done_nxt  = out_done_r;
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      out_done_nxt  = 1'b0;
      out_data_nxt  = rd_ok_r ? 32'(nv_rdata_r) : '0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_done_nxt  = 1'b1;
      out_data_nxt  = '0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      cp_vld_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cp_vld_r    <= (state_r == ST_COPY);
      s1_vld_r    <= (state_r == ST_CALC);
      s2_vld_r    <= s1_vld_r;
      rd_pend_r   <= in_accept && in_kind == gme_pkg::KIND_READ;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and counters that only matter while their owner state is active.
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    pass_left_r <= pass_left_nxt;
    cnt_r       <= cnt_nxt;
    node_r      <= node_nxt;
    op_r        <= op_nxt;
    adj_addr_r  <= adj_addr_nxt;
    cp_addr_r   <= cnt_r;
    s1_self_r   <= (op_r == '0);
    s1_last_r   <= (op_r == OPW'(MAX_DEGREE));
    s1_node_r   <= node_r;
    s2_self_r   <= s1_self_r;
    s2_last_r   <= s1_last_r;
    s2_use_r    <= s1_use;
    s2_node_r   <= s1_node_r;
    rd_ok_r     <= in_range;
    out_data_r  <= out_data_nxt;
    out_done_r  <= out_done_nxt;
    if (s2_vld_r) begin
      best_r <= best_new;
    end
  end

  // A run beat always leaves the idle state.
  a_run_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_kind == gme_pkg::KIND_RUN) |=> state_r != ST_IDLE)
    else $error("run beat accepted but sequencer stayed idle");

  // A read answer never lands on a result that is still waiting.
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (!out_valid_r || out_tready))
    else $error("read answer would overwrite a pending result");

  // Write-backs only happen while a pass is computing or draining.
  a_writeback_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (state_r == ST_CALC || state_r == ST_DRAIN))
    else $error("erosion write-back outside a pass");

  // The copy sweep and the erosion pipeline never overlap.
  a_copy_vs_calc: assert property (@(posedge clk) disable iff (!rst_n)
    cp_vld_r |-> (!s1_vld_r && !s2_vld_r))
    else $error("copy sweep overlaps erosion pipeline");

  // No input beat is taken while the adjacency table is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == ST_CLEAR) && state_r == ST_CLEAR |-> !in_tready)
    else $error("input taken during adjacency clearing");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the graph minimum erosion unit: predictor, stimulus and checks.

// One beat of the input channel, unpacked into its fields.
typedef struct {
  logic [1:0]  kind;
  logic [9:0]  node;
  logic [2:0]  slot;
  logic [9:0]  nbr;
  logic        nbr_valid;
  logic [31:0] value;
} graph_item_t;

// One beat of the result channel.
typedef struct {
  logic        is_done;
  logic [31:0] read_value;
} node_answer_t;

// Keeps a private copy of the graph and the registers, works out the answer of every
// accepted beat and compares the result beats against those answers in order.
class erosion_scoreboard;
  localparam int NODES  = 1024;
  localparam int DEGREE = 8;

  logic [7:0]         passes;
  logic [10:0]        nodes_in_use;
  logic signed [31:0] node_val [NODES];
  logic [9:0]         adj_nbr [NODES*DEGREE];
  logic               adj_vld [NODES*DEGREE];
  node_answer_t       awaited [$];
  int unsigned        mismatches;

  function new();
    passes       = gme_pkg::PASS_COUNT_RESET;
    nodes_in_use = gme_pkg::NODE_COUNT_RESET;
    mismatches   = 0;
    foreach (node_val[k]) node_val[k] = '0;
    foreach (adj_vld[k]) begin
      adj_vld[k] = 1'b0;
      adj_nbr[k] = '0;
    end
  endfunction

  function void set_reg(logic reg_idx, logic [31:0] data);
    if (reg_idx == gme_pkg::REG_PASS_COUNT) begin
      passes = data[7:0];
    end else begin
      nodes_in_use = data[10:0];
    end
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // All passes of one run; every pass reads only the values of the pass before it.
  function void erode_graph();
    logic signed [31:0] prev [NODES];
    logic signed [31:0] best;
    int unsigned        n;
    int unsigned        k;
    n = (nodes_in_use > NODES) ? NODES : nodes_in_use;
    for (int p = 0; p < passes; p++) begin
      prev = node_val;
      for (int i = 0; i < n; i++) begin
        best = prev[i];
        for (int s = 0; s < DEGREE; s++) begin
          k = i * DEGREE + s;
          if (adj_vld[k] && adj_nbr[k] < n && prev[adj_nbr[k]] < best) begin
            best = prev[adj_nbr[k]];
          end
        end
        node_val[i] = best;
      end
    end
  endfunction

  function void note_item(graph_item_t it);
    case (it.kind)
      gme_pkg::KIND_WRITE_VALUE: node_val[it.node] = it.value;
      gme_pkg::KIND_WRITE_SLOT: begin
        adj_nbr[it.node * DEGREE + it.slot] = it.nbr;
        adj_vld[it.node * DEGREE + it.slot] = it.nbr_valid;
      end
      gme_pkg::KIND_RUN: begin
        erode_graph();
        awaited.push_back('{1'b1, 32'd0});
      end
      gme_pkg::KIND_READ: awaited.push_back('{1'b0, node_val[it.node]});
      default: ;
    endcase
  endfunction

  task check_result(logic is_done, logic [31:0] data);
    node_answer_t want;
    if (awaited.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing awaited: is_done=%0b value=%08h",
                                is_done, data));
      return;
    end
    want = awaited.pop_front();
    if (is_done !== want.is_done) begin
      report_mismatch($sformatf("is_done %0b, predicted %0b", is_done, want.is_done));
    end
    if (data !== want.read_value) begin
      report_mismatch($sformatf("read_value %08h, predicted %08h", data, want.read_value));
    end
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gme_pkg::*;

  // The run is killed here; the slowest correct run stays well below it, including the
  // adjacency clearing sweep after reset and the runs over all 1024 nodes.
  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  // Long receiver hold that lets the unit fill its output and stall its input.
  localparam int unsigned HOLD_CYCLES  = 400;
  // Cycles allowed after the last answer for trailing writes to retire.
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int          RANDOM_PHASES = 22;
  localparam int          PHASE_BEATS   = 30;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic        cfg_pready;

  erosion_scoreboard scoreboard;
  int unsigned       cycle_count = 0;
  // Percentage of cycles in which each side idles; zero during the busy stretch.
  int unsigned       gap_pct     = 24;
  // Each bump of hold_token asks the receiver for one long hold.
  int unsigned       hold_token  = 0;
  int unsigned       hold_seen   = 0;
  int unsigned       hold_left   = 0;

  graph_min_erosion_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Receiver: random back-pressure, plus the long hold counted here in cycles.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= gap_pct);
    end
  end

  // Every result beat is checked at the edge that accepts it; signals are read before
  // the edge's updates land, so the check sees what the handshake saw.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      scoreboard.check_result(out_tuser[0], out_tdata);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic graph_item_t make_item(logic [1:0] kind, logic [9:0] node,
                                             logic [2:0] slot, logic [9:0] nbr,
                                             logic nbr_valid, logic [31:0] value);
    graph_item_t it;
    it.kind      = kind;
    it.node      = node;
    it.slot      = slot;
    it.nbr       = nbr;
    it.nbr_valid = nbr_valid;
    it.value     = value;
    return it;
  endfunction

  // Node values lean toward the signed extremes so that the minimum search meets them.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Most beats address nodes in use and link them to each other, so runs see real
  // neighborhoods; the rest hit any node or point at neighbors past the node count.
  function automatic graph_item_t random_item(int unsigned span);
    graph_item_t it;
    int unsigned lim;
    int unsigned roll;
    lim  = (span == 0) ? 1 : span;
    roll = $urandom_range(99);
    if (roll < 34) begin
      it.kind = KIND_WRITE_VALUE;
    end else if (roll < 62) begin
      it.kind = KIND_WRITE_SLOT;
    end else if (roll < 70) begin
      it.kind = KIND_RUN;
    end else begin
      it.kind = KIND_READ;
    end
    it.node      = ($urandom_range(99) < 80) ? 10'($urandom_range(0, lim - 1)) : 10'($urandom);
    it.slot      = 3'($urandom);
    it.nbr       = ($urandom_range(99) < 75) ? 10'($urandom_range(0, lim - 1)) : 10'($urandom);
    it.nbr_valid = ($urandom_range(99) < 85);
    it.value     = pick_value();
    return it;
  endfunction

  // Offers one beat, with a random gap in front of it, and returns at the edge that
  // takes it. in_tvalid stays high when the next beat follows without a gap.
  task automatic send_item(graph_item_t it);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {it.value, it.nbr_valid, it.nbr, it.slot, it.node};
    do @(posedge clk); while (!in_tready);
    scoreboard.note_item(it);
  endtask

  // Stops offering beats until every awaited answer is back and trailing writes retired.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write followed by a read back of the same register; returns once the port
  // has gone idle.
  task automatic cfg_write(logic reg_idx, logic [31:0] data);
    logic [31:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    scoreboard.set_reg(reg_idx, data);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    if (reg_idx == REG_PASS_COUNT && got[7:0] !== scoreboard.passes) begin
      scoreboard.report_mismatch($sformatf("pass_count reads %02h, written %02h",
                                           got[7:0], scoreboard.passes));
    end
    if (reg_idx == REG_NODE_COUNT && got[10:0] !== scoreboard.nodes_in_use) begin
      scoreboard.report_mismatch($sformatf("node_count reads %03h, written %03h",
                                           got[10:0], scoreboard.nodes_in_use));
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    graph_item_t it;
    int unsigned nodes;
    int unsigned passes;
    int unsigned span;
    scoreboard  = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = KIND_WRITE_VALUE;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on a four-node graph. Every node a run touches is written first.
    // Node 0 sees node 2, node 2 sees node 1 (the most negative value), node 3 has an
    // empty slot and a neighbor past the node count, and node 1023 lies outside the
    // nodes in use but links back into them. The beats stall until the clearing sweep
    // after reset is over.
    cfg_write(REG_PASS_COUNT, 32'd1);
    cfg_write(REG_NODE_COUNT, 32'd4);
    send_item(make_item(KIND_WRITE_VALUE, 10'd0, 3'd0, 10'd0, 1'b0, 32'h7FFF_FFFF));
    send_item(make_item(KIND_WRITE_VALUE, 10'd1, 3'd0, 10'd0, 1'b0, 32'h8000_0000));
    send_item(make_item(KIND_WRITE_VALUE, 10'd2, 3'd0, 10'd0, 1'b0, 32'h0000_0000));
    send_item(make_item(KIND_WRITE_VALUE, 10'd3, 3'd0, 10'd0, 1'b0, 32'hFFFF_FFFF));
    send_item(make_item(KIND_WRITE_VALUE, 10'd1023, 3'd0, 10'd0, 1'b0, 32'h1234_5678));
    send_item(make_item(KIND_WRITE_VALUE, 10'd512, 3'd0, 10'd0, 1'b0, 32'd5));
    send_item(make_item(KIND_WRITE_SLOT, 10'd0, 3'd0, 10'd2, 1'b1, 32'd0));
    send_item(make_item(KIND_WRITE_SLOT, 10'd2, 3'd7, 10'd1, 1'b1, 32'd0));
    send_item(make_item(KIND_WRITE_SLOT, 10'd3, 3'd3, 10'd1, 1'b0, 32'd0));
    send_item(make_item(KIND_WRITE_SLOT, 10'd3, 3'd4, 10'd1023, 1'b1, 32'd0));
    send_item(make_item(KIND_WRITE_SLOT, 10'd1023, 3'd5, 10'd0, 1'b1, 32'd0));
    send_item(make_item(KIND_RUN, 10'd0, 3'd0, 10'd0, 1'b0, 32'd0));
    send_item(make_item(KIND_READ, 10'd0, 3'd0, 10'd0, 1'b0, 32'd0));
    send_item(make_item(KIND_READ, 10'd1, 3'd0, 10'd0, 1'b0, 32'd0));
    send_item(make_item(KIND_READ, 10'd2, 3'd0, 10'd0, 1'b0, 32'd0));
    send_item(make_item(KIND_READ, 10'd3, 3'd0, 10'd0, 1'b0, 32'd0));
    send_item(make_item(KIND_READ, 10'd1023, 3'd0, 10'd0, 1'b0, 32'd0));
    send_item(make_item(KIND_READ, 10'd512, 3'd0, 10'd0, 1'b0, 32'd0));

    // A run with zero passes still reports completion and changes nothing.
    wait_idle();
    cfg_write(REG_PASS_COUNT, 32'd0);
    send_item(make_item(KIND_RUN, 10'd0, 3'd0, 10'd0, 1'b0, 32'd0));
    send_item(make_item(KIND_READ, 10'd0, 3'd0, 10'd0, 1'b0, 32'd0));

    // With no nodes in use a run processes nothing.
    wait_idle();
    cfg_write(REG_PASS_COUNT, 32'd3);
    cfg_write(REG_NODE_COUNT, 32'd0);
    send_item(make_item(KIND_RUN, 10'd0, 3'd0, 10'd0, 1'b0, 32'd0));
    send_item(make_item(KIND_READ, 10'd2, 3'd0, 10'd0, 1'b0, 32'd0));

    // Most passes on a single node whose only neighbor is out of range.
    wait_idle();
    cfg_write(REG_PASS_COUNT, 32'd255);
    cfg_write(REG_NODE_COUNT, 32'd1);
    send_item(make_item(KIND_RUN, 10'd0, 3'd0, 10'd0, 1'b0, 32'd0));
    send_item(make_item(KIND_READ, 10'd0, 3'd0, 10'd0, 1'b0, 32'd0));

    // Load every node, then run over the full graph at the reset settings, and once
    // more with a node count above the node memory, which saturates.
    wait_idle();
    cfg_write(REG_PASS_COUNT, 32'(PASS_COUNT_RESET));
    cfg_write(REG_NODE_COUNT, 32'(NODE_COUNT_RESET));
    for (int i = 0; i < 1024; i++) begin
      send_item(make_item(KIND_WRITE_VALUE, 10'(i), 3'd0, 10'd0, 1'b0, pick_value()));
    end
    repeat (24) begin
      it      = random_item(1024);
      it.kind = KIND_WRITE_SLOT;
      send_item(it);
    end
    send_item(make_item(KIND_RUN, 10'd0, 3'd0, 10'd0, 1'b0, 32'd0));
    repeat (8) begin
      it      = random_item(1024);
      it.kind = KIND_READ;
      send_item(it);
    end
    wait_idle();
    cfg_write(REG_PASS_COUNT, 32'd1);
    cfg_write(REG_NODE_COUNT, 32'd2047);
    send_item(make_item(KIND_RUN, 10'd0, 3'd0, 10'd0, 1'b0, 32'd0));
    repeat (8) begin
      it      = random_item(1024);
      it.kind = KIND_READ;
      send_item(it);
    end

    // Random phases. Every node holds a written value from here on, so any read or run
    // is legal. Each phase starts idle, picks new settings and sends a burst of beats.
    // Large graphs get at most one pass per run to keep the run short.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      if (ph == 0) begin
        nodes  = 1;
        passes = 1;
      end else if (ph == 1) begin
        nodes  = 2;
        passes = 255;
      end else if ($urandom_range(99) < 10) begin
        nodes  = $urandom_range(1025, 2047);
        passes = $urandom_range(0, 1);
      end else if ($urandom_range(99) < 6) begin
        nodes  = 0;
        passes = $urandom_range(0, 255);
      end else begin
        nodes  = $urandom_range(1, 48);
        passes = $urandom_range(0, 4);
      end
      // A stretch of phases runs with both sides busy on every cycle.
      gap_pct <= (ph >= 6 && ph < 10) ? 0 : 24;
      cfg_write(REG_PASS_COUNT, passes);
      cfg_write(REG_NODE_COUNT, nodes);
      // One phase opens with a long receiver hold while beats keep coming.
      if (ph == 4) begin
        hold_token <= hold_token + 1;
      end
      span = (nodes > 1024) ? 1024 : nodes;
      repeat (PHASE_BEATS) send_item(random_item(span));
    end

    wait_idle();
    if (scoreboard.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/gme_pkg.sv
rtl/core/gme_regs.sv
rtl/core/graph_min_erosion_unit.sv
tb/testbench.sv
